// ----- rtl/hpc_pkg.sv -----
// Package with the types, constants and helper functions of the page cache tag table.
package hpc_pkg;

  localparam int unsigned Entries = 32;
  localparam int unsigned IdxW    = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned SpinW   = IdxW + 1;
  localparam int unsigned ResW    = 6;
  localparam int unsigned ResMax  = 63;

  localparam logic [63:0] HashMulFile = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] HashMulPage = 64'hC2B2_AE3D_27D4_EB4F;
  localparam int unsigned PageShift   = 12;

  typedef logic [IdxW-1:0] idx_t;

  typedef enum logic {
    CMD_GET    = 1'b0,
    CMD_FORGET = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    FILL_OK      = 2'd0,
    FILL_NOFRAME = 2'd1,
    FILL_FAILED  = 2'd2,
    FILL_FAILED3 = 2'd3
  } fill_e;

  typedef enum logic {
    KIND_RELEASE = 1'b0,
    KIND_FINAL   = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    RES_HIT      = 3'd0,
    RES_MISS     = 3'd1,
    RES_INVALID  = 3'd2,
    RES_NOFRAME  = 3'd3,
    RES_READFAIL = 3'd4,
    RES_NOROOM   = 3'd5,
    RES_FORGET   = 3'd6
  } res_e;

  typedef enum logic [3:0] {
    FSM_IDLE,
    FSM_HASH,
    FSM_PROBE,
    FSM_EVICT,
    FSM_PLACE,
    FSM_FG_CNT,
    FSM_FG_REL,
    FSM_EMIT
  } fsm_e;

  typedef enum logic [1:0] {
    HPH_IDLE,
    HPH_MIX,
    HPH_MOD,
    HPH_DONE
  } hash_ph_e;

  typedef struct packed {
    logic        used;
    logic [31:0] file;
    logic [63:0] offset;
    logic [63:0] frame;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    logic        start;
    logic [31:0] file_id;
    logic [63:0] offset;
  } hash_req_t;

  typedef struct packed {
    logic done;
    idx_t slot;
  } hash_rsp_t;

  function automatic idx_t idx_inc(input idx_t a);
    idx_t r;
    if (a == IdxW'(Entries - 1)) begin
      r = '0;
    end else begin
      r = a + idx_t'(1);
    end
    return r;
  endfunction

  function automatic idx_t mod_byte(input idx_t rem, input logic [7:0] b);
    logic [IdxW:0] t;
    idx_t          r;
    r = rem;
    for (int k = 7; k >= 0; k--) begin
      t = {r, b[k]};
      if (t >= (IdxW + 1)'(Entries)) begin
        t = t - (IdxW + 1)'(Entries);
      end
      r = t[IdxW-1:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/hpc_if.sv -----
// Valid/ready channel interfaces for the request and result transactions.
interface hpc_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] file_id;
  logic [63:0] offset;
  logic [63:0] fill_frame;
  logic [1:0]  fill_status;

  modport source (output valid, cmd, file_id, offset, fill_frame, fill_status, input ready);
  modport sink (input valid, cmd, file_id, offset, fill_frame, fill_status, output ready);
endinterface

interface hpc_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [2:0]  status;
  logic [63:0] frame;
  logic [5:0]  resident;
  logic        last;

  modport source (output valid, kind, status, frame, resident, last, input ready);
  modport sink (input valid, kind, status, frame, resident, last, output ready);
endinterface

// ----- rtl/hpc_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered, write-first read.
module hpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [AddrW-1:0]       waddr_i,
  input  logic [Width-1:0]       wdata_i,
  input  logic [AddrW-1:0]       raddr_i,
  output logic [Width-1:0]       rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ----- rtl/hpc_hash.sv -----
// Multi-cycle home slot hash: split 32-bit partial products, xor, then a bytewise modulo.
module hpc_hash (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hpc_pkg::hash_req_t req_i,
  output hpc_pkg::hash_rsp_t rsp_o
);
  hpc_pkg::hash_ph_e ph_q, ph_d;
  logic [1:0]        k_q;
  logic [63:0]       pf_lo_q, pp_lo_q;
  logic [31:0]       pf_hi_q, pp_mid_q, pp_top_q;
  logic [31:0]       x_q;
  hpc_pkg::idx_t     rem_q;
  logic [51:0]       page;
  logic [63:0]       pf_lo_full, pp_lo_full;
  logic [31:0]       hi_f, hi_p;

  assign page = 52'(req_i.offset >> hpc_pkg::PageShift);
  assign hi_f = pf_lo_q[63:32] + pf_hi_q;
  assign hi_p = pp_lo_q[63:32] + pp_mid_q + pp_top_q;
  assign pf_lo_full = 64'(req_i.file_id) * 64'(hpc_pkg::HashMulFile[31:0]);
  assign pp_lo_full = 64'(page[31:0]) * 64'(hpc_pkg::HashMulPage[31:0]);

  always_comb begin
    ph_d = ph_q;
    case (ph_q)
      hpc_pkg::HPH_IDLE: if (req_i.start) ph_d = hpc_pkg::HPH_MIX;
      hpc_pkg::HPH_MIX:  ph_d = hpc_pkg::HPH_MOD;
      hpc_pkg::HPH_MOD:  if (k_q == 2'd3) ph_d = hpc_pkg::HPH_DONE;
      hpc_pkg::HPH_DONE: ph_d = hpc_pkg::HPH_IDLE;
      default:           ph_d = hpc_pkg::HPH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= hpc_pkg::HPH_IDLE;
      k_q  <= '0;
    end else begin
      ph_q <= ph_d;
      if (ph_q == hpc_pkg::HPH_MOD) begin
        k_q <= k_q + 2'd1;
      end else begin
        k_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      pf_lo_q  <= pf_lo_full;
      pf_hi_q  <= 32'(req_i.file_id * hpc_pkg::HashMulFile[63:32]);
      pp_lo_q  <= pp_lo_full;
      pp_mid_q <= 32'(page[31:0] * hpc_pkg::HashMulPage[63:32]);
      pp_top_q <= 32'({12'd0, page[51:32]} * hpc_pkg::HashMulPage[31:0]);
    end
    if (ph_q == hpc_pkg::HPH_MIX) begin
      x_q   <= hi_f ^ hi_p;
      rem_q <= '0;
    end else if (ph_q == hpc_pkg::HPH_MOD) begin
      x_q   <= {x_q[23:0], 8'd0};
      rem_q <= hpc_pkg::mod_byte(rem_q, x_q[31:24]);
    end
  end

  assign rsp_o.done = (ph_q == hpc_pkg::HPH_DONE);
  assign rsp_o.slot = rem_q;
endmodule

// ----- rtl/hashed_page_cache_clock_evict.sv -----
// Top level of the page cache tag table with clock replacement.
// One request transaction is handled at a time. A get is first hashed, in a unit built from
// parallel 32-bit partial products and a bytewise modulo, then probes the tag RAM slot by
// slot from the home slot; a miss then sweeps the clock hand (over at most 2*Entries slots)
// and probes again from the home slot while placing. A forget makes two passes over the
// table, and the second pass waits whenever a release cannot be loaded into the output
// register. Every result transaction is held in the output register until it is taken, and
// the request side is ready again once the final result has been loaded.
// The store is cleared at reset through per-slot valid bits, so no clearing pass is needed.
module hashed_page_cache_clock_evict (
  input  logic     clk_i,
  input  logic     rst_ni,
  hpc_in_if.sink   in_i,
  hpc_out_if.source out_o
);
  hpc_pkg::fsm_e   state_q, state_d;
  hpc_pkg::idx_t   addr_q, addr_d, idx_q, idx_d, hand_q, hand_d, home_q, home_d;
  logic [hpc_pkg::SpinW-1:0] spin_q, spin_d;
  logic [hpc_pkg::ResW-1:0]  cnt_q, cnt_d, fgn_q, fgn_d;
  logic            ev_pend_q, ev_pend_d, fill_pend_q, fill_pend_d;
  logic [63:0]     ev_frame_q, ev_frame_d, fin_frame_q, fin_frame_d;
  logic [2:0]      fin_status_q, fin_status_d;
  logic [31:0]     fid_q;
  logic [63:0]     off_q, fill_q;
  logic [1:0]      fst_q;
  logic            accept;

  logic            ovalid_q, ovalid_d, out_free, emit;
  logic            okind_d, okind_q;
  logic [2:0]      ostatus_d, ostatus_q;
  logic [63:0]     oframe_d, oframe_q;
  logic [hpc_pkg::ResW-1:0] ores_q;

  logic            we;
  hpc_pkg::entry_t wdata, rd_ent, ram_rdata;
  logic [hpc_pkg::Entries-1:0] vld_q;
  logic            vld_rd_q;

  hpc_pkg::hash_req_t hreq;
  hpc_pkg::hash_rsp_t hrsp;

  assign accept   = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == hpc_pkg::FSM_IDLE);
  assign out_free = !ovalid_q || out_o.ready;

  assign hreq.start   = accept && (in_i.cmd == hpc_pkg::CMD_GET) && (in_i.file_id != 32'd0);
  assign hreq.file_id = in_i.file_id;
  assign hreq.offset  = in_i.offset;

  hpc_hash u_hash (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (hreq),
    .rsp_o (hrsp)
  );

  hpc_ram #(
    .Width(hpc_pkg::EntryW),
    .Depth(hpc_pkg::Entries)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(addr_q),
    .wdata_i(wdata),
    .raddr_i(addr_d),
    .rdata_o(ram_rdata)
  );

  assign rd_ent = vld_rd_q ? ram_rdata : '0;

  always_comb begin
    state_d      = state_q;
    addr_d       = addr_q;
    idx_d        = idx_q;
    hand_d       = hand_q;
    home_d       = home_q;
    spin_d       = spin_q;
    cnt_d        = cnt_q;
    fgn_d        = fgn_q;
    ev_pend_d    = ev_pend_q;
    fill_pend_d  = fill_pend_q;
    ev_frame_d   = ev_frame_q;
    fin_frame_d  = fin_frame_q;
    fin_status_d = fin_status_q;
    we           = 1'b0;
    wdata        = rd_ent;
    emit         = 1'b0;
    okind_d      = hpc_pkg::KIND_RELEASE;
    ostatus_d    = hpc_pkg::RES_HIT;
    oframe_d     = '0;
    case (state_q)
      hpc_pkg::FSM_IDLE: begin
        if (accept) begin
          ev_pend_d   = 1'b0;
          fill_pend_d = 1'b0;
          fin_frame_d = '0;
          if (in_i.file_id == 32'd0) begin
            fin_status_d = hpc_pkg::RES_INVALID;
            state_d      = hpc_pkg::FSM_EMIT;
          end else if (in_i.cmd == hpc_pkg::CMD_FORGET) begin
            addr_d  = '0;
            fgn_d   = '0;
            state_d = hpc_pkg::FSM_FG_CNT;
          end else begin
            state_d = hpc_pkg::FSM_HASH;
          end
        end
      end
      hpc_pkg::FSM_HASH: begin
        if (hrsp.done) begin
          addr_d  = hrsp.slot;
          home_d  = hrsp.slot;
          idx_d   = '0;
          state_d = hpc_pkg::FSM_PROBE;
        end
      end
      hpc_pkg::FSM_PROBE: begin
        if (rd_ent.file != 32'd0 && rd_ent.file == fid_q && rd_ent.offset == off_q) begin
          we           = 1'b1;
          wdata.used   = 1'b1;
          fin_status_d = hpc_pkg::RES_HIT;
          fin_frame_d  = rd_ent.frame;
          state_d      = hpc_pkg::FSM_EMIT;
        end else if (rd_ent.file == 32'd0 || idx_q == hpc_pkg::IdxW'(hpc_pkg::Entries - 1)) begin
          case (fst_q)
            hpc_pkg::FILL_OK: begin
              addr_d  = hand_q;
              spin_d  = '0;
              state_d = hpc_pkg::FSM_EVICT;
            end
            hpc_pkg::FILL_NOFRAME: begin
              fin_status_d = hpc_pkg::RES_NOFRAME;
              state_d      = hpc_pkg::FSM_EMIT;
            end
            default: begin
              fill_pend_d  = 1'b1;
              fin_status_d = hpc_pkg::RES_READFAIL;
              state_d      = hpc_pkg::FSM_EMIT;
            end
          endcase
        end else begin
          idx_d  = idx_q + hpc_pkg::idx_t'(1);
          addr_d = hpc_pkg::idx_inc(addr_q);
        end
      end
      hpc_pkg::FSM_EVICT: begin
        hand_d = hpc_pkg::idx_inc(addr_q);
        if (rd_ent.file == 32'd0) begin
          addr_d  = home_q;
          idx_d   = '0;
          state_d = hpc_pkg::FSM_PLACE;
        end else if (rd_ent.used) begin
          we         = 1'b1;
          wdata.used = 1'b0;
          if (spin_q == hpc_pkg::SpinW'(2 * hpc_pkg::Entries - 1)) begin
            fill_pend_d  = 1'b1;
            fin_status_d = hpc_pkg::RES_NOROOM;
            state_d      = hpc_pkg::FSM_EMIT;
          end else begin
            spin_d = spin_q + hpc_pkg::SpinW'(1);
            addr_d = hpc_pkg::idx_inc(addr_q);
          end
        end else begin
          we          = 1'b1;
          wdata.file  = '0;
          wdata.frame = '0;
          ev_pend_d   = 1'b1;
          ev_frame_d  = rd_ent.frame;
          if (cnt_q != '0) begin
            cnt_d = cnt_q - hpc_pkg::ResW'(1);
          end
          addr_d  = home_q;
          idx_d   = '0;
          state_d = hpc_pkg::FSM_PLACE;
        end
      end
      hpc_pkg::FSM_PLACE: begin
        if (rd_ent.file == 32'd0) begin
          we           = 1'b1;
          wdata.used   = 1'b1;
          wdata.file   = fid_q;
          wdata.offset = off_q;
          wdata.frame  = fill_q;
          if (cnt_q != hpc_pkg::ResW'(hpc_pkg::ResMax)) begin
            cnt_d = cnt_q + hpc_pkg::ResW'(1);
          end
          fin_status_d = hpc_pkg::RES_MISS;
          fin_frame_d  = fill_q;
          state_d      = hpc_pkg::FSM_EMIT;
        end else if (idx_q == hpc_pkg::IdxW'(hpc_pkg::Entries - 1)) begin
          fill_pend_d  = 1'b1;
          fin_status_d = hpc_pkg::RES_NOROOM;
          state_d      = hpc_pkg::FSM_EMIT;
        end else begin
          idx_d  = idx_q + hpc_pkg::idx_t'(1);
          addr_d = hpc_pkg::idx_inc(addr_q);
        end
      end
      hpc_pkg::FSM_FG_CNT: begin
        if (rd_ent.file == fid_q) begin
          fgn_d = fgn_q + hpc_pkg::ResW'(1);
        end
        if (addr_q == hpc_pkg::IdxW'(hpc_pkg::Entries - 1)) begin
          cnt_d   = (cnt_q > fgn_d) ? (cnt_q - fgn_d) : '0;
          addr_d  = '0;
          state_d = hpc_pkg::FSM_FG_REL;
        end else begin
          addr_d = hpc_pkg::idx_inc(addr_q);
        end
      end
      hpc_pkg::FSM_FG_REL: begin
        if (rd_ent.file == fid_q && !out_free) begin
          addr_d = addr_q;
        end else begin
          if (rd_ent.file == fid_q) begin
            we          = 1'b1;
            wdata.file  = '0;
            wdata.frame = '0;
            wdata.used  = 1'b0;
            emit        = 1'b1;
            oframe_d    = rd_ent.frame;
          end
          if (addr_q == hpc_pkg::IdxW'(hpc_pkg::Entries - 1)) begin
            fin_status_d = hpc_pkg::RES_FORGET;
            state_d      = hpc_pkg::FSM_EMIT;
          end else begin
            addr_d = hpc_pkg::idx_inc(addr_q);
          end
        end
      end
      hpc_pkg::FSM_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          if (ev_pend_q) begin
            ev_pend_d = 1'b0;
            oframe_d  = ev_frame_q;
          end else if (fill_pend_q) begin
            fill_pend_d = 1'b0;
            oframe_d    = fill_q;
          end else begin
            okind_d   = hpc_pkg::KIND_FINAL;
            ostatus_d = fin_status_q;
            oframe_d  = fin_frame_q;
            state_d   = hpc_pkg::FSM_IDLE;
          end
        end
      end
      default: state_d = hpc_pkg::FSM_IDLE;
    endcase
  end

  always_comb begin
    if (emit) begin
      ovalid_d = 1'b1;
    end else if (out_o.ready) begin
      ovalid_d = 1'b0;
    end else begin
      ovalid_d = ovalid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hpc_pkg::FSM_IDLE;
      addr_q      <= '0;
      idx_q       <= '0;
      hand_q      <= '0;
      home_q      <= '0;
      spin_q      <= '0;
      cnt_q       <= '0;
      fgn_q       <= '0;
      ev_pend_q   <= 1'b0;
      fill_pend_q <= 1'b0;
      ovalid_q    <= 1'b0;
      vld_q       <= '0;
      vld_rd_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      addr_q      <= addr_d;
      idx_q       <= idx_d;
      hand_q      <= hand_d;
      home_q      <= home_d;
      spin_q      <= spin_d;
      cnt_q       <= cnt_d;
      fgn_q       <= fgn_d;
      ev_pend_q   <= ev_pend_d;
      fill_pend_q <= fill_pend_d;
      ovalid_q    <= ovalid_d;
      if (we) begin
        vld_q[addr_q] <= 1'b1;
      end
      vld_rd_q <= (we && addr_q == addr_d) ? 1'b1 : vld_q[addr_d];
    end
  end

  always_ff @(posedge clk_i) begin
    ev_frame_q   <= ev_frame_d;
    fin_frame_q  <= fin_frame_d;
    fin_status_q <= fin_status_d;
    if (accept) begin
      fid_q  <= in_i.file_id;
      off_q  <= in_i.offset;
      fill_q <= in_i.fill_frame;
      fst_q  <= in_i.fill_status;
    end
    if (emit) begin
      okind_q   <= okind_d;
      ostatus_q <= ostatus_d;
      oframe_q  <= oframe_d;
      ores_q    <= cnt_q;
    end
  end

  assign out_o.valid    = ovalid_q;
  assign out_o.kind     = okind_q;
  assign out_o.status   = ostatus_q;
  assign out_o.frame    = oframe_q;
  assign out_o.resident = ores_q;
  assign out_o.last     = okind_q;
endmodule

// ----- rtl/hpc_checker.sv -----
// Port-level checker for the page cache tag table, bound to the top level.
module hpc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_kind_i,
  input logic [2:0]  out_status_i,
  input logic [63:0] out_frame_i,
  input logic        out_last_i
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_frame_i))
    else $error("Result transaction changed while stalled.");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("Request accepted while another was in progress.");

  a_last_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (out_last_i == out_kind_i))
    else $error("Last flag does not match the final answer.");

  a_release_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == hpc_pkg::KIND_RELEASE) |-> out_status_i == hpc_pkg::RES_HIT)
    else $error("Release result carries a status.");

  a_zero_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == hpc_pkg::KIND_FINAL) && out_status_i != hpc_pkg::RES_HIT &&
    out_status_i != hpc_pkg::RES_MISS |-> out_frame_i == 64'd0)
    else $error("Failed answer carries a frame.");
endmodule

bind hashed_page_cache_clock_evict hpc_checker u_hpc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_kind_i  (out_o.kind),
  .out_status_i(out_o.status),
  .out_frame_i (out_o.frame),
  .out_last_i  (out_o.last)
);

// ----- test/hashed_page_cache_clock_evict_tb.sv -----
// Self-checking testbench of the page cache tag table with clock replacement.
`timescale 1ns / 1ps

module hashed_page_cache_clock_evict_tb;

  localparam int unsigned StallLimit = 20000;

  typedef struct {
    hpc_pkg::cmd_e  cmd;
    logic [31:0]    file_id;
    logic [63:0]    offset;
    logic [63:0]    fill_frame;
    hpc_pkg::fill_e fill_status;
  } page_req_t;

  typedef struct {
    hpc_pkg::kind_e kind;
    hpc_pkg::res_e  status;
    logic [63:0]    frame;
    logic [5:0]     resident;
    logic           last;
  } page_rsp_t;

  class cache_scoreboard;
    page_rsp_t   pending[$];
    int unsigned errors;
    logic [31:0] tag_file[hpc_pkg::Entries];
    logic [63:0] tag_offset[hpc_pkg::Entries];
    logic [63:0] tag_frame[hpc_pkg::Entries];
    logic        tag_used[hpc_pkg::Entries];
    int unsigned hand;
    int unsigned resident;

    function new();
      errors = 0;
      hand = 0;
      resident = 0;
      for (int s = 0; s < hpc_pkg::Entries; s++) begin
        tag_file[s] = '0;
        tag_offset[s] = '0;
        tag_frame[s] = '0;
        tag_used[s] = 1'b0;
      end
    endfunction

    function int unsigned home_of(logic [31:0] fid, logic [63:0] off);
      logic [63:0] h;
      h = ({32'd0, fid} * hpc_pkg::HashMulFile) ^
          ((off >> hpc_pkg::PageShift) * hpc_pkg::HashMulPage);
      return h[63:32] % hpc_pkg::Entries;
    endfunction

    function bit sweep_hand(ref page_rsp_t step[$]);
      int unsigned s;
      for (int k = 0; k < 2 * hpc_pkg::Entries; k++) begin
        s = hand;
        hand = (s + 1) % hpc_pkg::Entries;
        if (tag_file[s] == '0) return 1'b1;
        if (tag_used[s]) begin
          tag_used[s] = 1'b0;
          continue;
        end
        step.push_back('{hpc_pkg::KIND_RELEASE, hpc_pkg::RES_HIT, tag_frame[s], 6'd0, 1'b0});
        tag_file[s] = '0;
        tag_frame[s] = '0;
        if (resident > 0) resident--;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_request(page_req_t r);
      page_rsp_t   step[$];
      int unsigned home;
      int unsigned s;
      bit          done;
      done = 1'b0;
      if (r.file_id == '0) begin
        step.push_back('{hpc_pkg::KIND_FINAL, hpc_pkg::RES_INVALID, 64'd0, 6'd0, 1'b1});
      end else if (r.cmd == hpc_pkg::CMD_FORGET) begin
        for (int i = 0; i < hpc_pkg::Entries; i++) begin
          if (tag_file[i] != r.file_id) continue;
          step.push_back('{hpc_pkg::KIND_RELEASE, hpc_pkg::RES_HIT, tag_frame[i], 6'd0, 1'b0});
          tag_file[i] = '0;
          tag_frame[i] = '0;
          tag_used[i] = 1'b0;
          if (resident > 0) resident--;
        end
        step.push_back('{hpc_pkg::KIND_FINAL, hpc_pkg::RES_FORGET, 64'd0, 6'd0, 1'b1});
      end else begin
        home = home_of(r.file_id, r.offset);
        for (int i = 0; i < hpc_pkg::Entries; i++) begin
          s = (home + i) % hpc_pkg::Entries;
          if (tag_file[s] == '0) break;
          if (tag_file[s] == r.file_id && tag_offset[s] == r.offset) begin
            tag_used[s] = 1'b1;
            step.push_back('{hpc_pkg::KIND_FINAL, hpc_pkg::RES_HIT, tag_frame[s], 6'd0, 1'b1});
            done = 1'b1;
            break;
          end
        end
        if (!done) begin
          if (r.fill_status == hpc_pkg::FILL_NOFRAME) begin
            step.push_back('{hpc_pkg::KIND_FINAL, hpc_pkg::RES_NOFRAME, 64'd0, 6'd0, 1'b1});
          end else if (r.fill_status != hpc_pkg::FILL_OK) begin
            step.push_back('{hpc_pkg::KIND_RELEASE, hpc_pkg::RES_HIT, r.fill_frame, 6'd0, 1'b0});
            step.push_back('{hpc_pkg::KIND_FINAL, hpc_pkg::RES_READFAIL, 64'd0, 6'd0, 1'b1});
          end else begin
            if (sweep_hand(step)) begin
              for (int i = 0; i < hpc_pkg::Entries; i++) begin
                s = (home + i) % hpc_pkg::Entries;
                if (tag_file[s] == '0) begin
                  tag_file[s] = r.file_id;
                  tag_offset[s] = r.offset;
                  tag_frame[s] = r.fill_frame;
                  tag_used[s] = 1'b1;
                  if (resident < hpc_pkg::ResMax) resident++;
                  step.push_back('{hpc_pkg::KIND_FINAL, hpc_pkg::RES_MISS, r.fill_frame,
                                   6'd0, 1'b1});
                  done = 1'b1;
                  break;
                end
              end
            end
            if (!done) begin
              step.push_back('{hpc_pkg::KIND_RELEASE, hpc_pkg::RES_HIT, r.fill_frame,
                               6'd0, 1'b0});
              step.push_back('{hpc_pkg::KIND_FINAL, hpc_pkg::RES_NOROOM, 64'd0, 6'd0, 1'b1});
            end
          end
        end
      end
      foreach (step[k]) begin
        step[k].resident = 6'(resident);
        pending.push_back(step[k]);
      end
    endfunction

    function void check_result(page_rsp_t got);
      page_rsp_t want;
      if (pending.size() == 0) begin
        $error("unexpected result kind %0d status %0d frame %h", got.kind, got.status, got.frame);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.kind != want.kind) begin
        $error("kind: expected %0d, actual %0d", want.kind, got.kind);
        errors++;
      end
      if (got.status != want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.frame != want.frame) begin
        $error("frame: expected %h, actual %h", want.frame, got.frame);
        errors++;
      end
      if (got.resident != want.resident) begin
        $error("resident: expected %0d, actual %0d", want.resident, got.resident);
        errors++;
      end
      if (got.last != want.last) begin
        $error("last: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned quiet_cycles = 0;
  cache_scoreboard sb = new();

  hpc_in_if  req_bus ();
  hpc_out_if rsp_bus ();

  hashed_page_cache_clock_evict uut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (req_bus),
    .out_o (rsp_bus)
  );

  always #2 clk = ~clk;

  initial begin
    req_bus.valid = 1'b0;
    req_bus.cmd = hpc_pkg::CMD_GET;
    req_bus.file_id = '0;
    req_bus.offset = '0;
    req_bus.fill_frame = '0;
    req_bus.fill_status = hpc_pkg::FILL_OK;
    rsp_bus.ready = 1'b0;
  end

  always @(negedge clk) begin
    rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && rsp_bus.valid && rsp_bus.ready) begin
      sb.check_result('{hpc_pkg::kind_e'(rsp_bus.kind), hpc_pkg::res_e'(rsp_bus.status),
                        rsp_bus.frame, rsp_bus.resident, rsp_bus.last});
    end
  end

  always @(posedge clk) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic send_request(page_req_t r);
    while ($urandom_range(99) < idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.cmd <= r.cmd;
    req_bus.file_id <= r.file_id;
    req_bus.offset <= r.offset;
    req_bus.fill_frame <= r.fill_frame;
    req_bus.fill_status <= r.fill_status;
    do @(posedge clk); while (!req_bus.ready);
    sb.note_request(r);
    @(negedge clk);
  endtask

  task automatic drain();
    req_bus.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
  endtask

  function automatic page_req_t random_request();
    page_req_t   r;
    logic [31:0] fid_pool[6];
    logic [63:0] off_pool[8];
    fid_pool = '{32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'hFFFF_FFFF};
    off_pool = '{64'd0, 64'h1000, 64'h2000, 64'h3004, 64'h1_0000, 64'hFFFF_FFFF_FFFF_FFFF,
                 64'h8000_0000_0000_0000, 64'h7000};
    r.cmd = ($urandom_range(99) < 6) ? hpc_pkg::CMD_FORGET : hpc_pkg::CMD_GET;
    case ($urandom_range(99)) inside
      [0:2]:   r.file_id = '0;
      [3:8]:   r.file_id = $urandom;
      default: r.file_id = fid_pool[$urandom_range(5)];
    endcase
    r.offset = ($urandom_range(99) < 10) ? {$urandom, $urandom} : off_pool[$urandom_range(7)];
    r.fill_frame = {$urandom, $urandom};
    r.fill_status = ($urandom_range(99) < 80) ? hpc_pkg::FILL_OK :
                    hpc_pkg::fill_e'($urandom_range(3));
    return r;
  endfunction

  initial begin
    page_req_t r;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_request('{hpc_pkg::CMD_GET, 32'd0, 64'd0, 64'd5, hpc_pkg::FILL_OK});
    send_request('{hpc_pkg::CMD_FORGET, 32'd0, 64'd0, 64'd0, hpc_pkg::FILL_OK});
    send_request('{hpc_pkg::CMD_GET, 32'hFFFF_FFFF, '1, '1, hpc_pkg::FILL_OK});
    send_request('{hpc_pkg::CMD_GET, 32'hFFFF_FFFF, '1, 64'd9, hpc_pkg::FILL_OK});
    send_request('{hpc_pkg::CMD_GET, 32'd1, 64'd0, 64'd0, hpc_pkg::FILL_OK});
    send_request('{hpc_pkg::CMD_GET, 32'd1, 64'd0, 64'd7, hpc_pkg::FILL_OK});
    send_request('{hpc_pkg::CMD_GET, 32'd1, 64'h1000, 64'hAA, hpc_pkg::FILL_NOFRAME});
    send_request('{hpc_pkg::CMD_GET, 32'd1, 64'h1000, '1, hpc_pkg::FILL_FAILED});
    send_request('{hpc_pkg::CMD_GET, 32'd1, 64'h1000, 64'h55, hpc_pkg::FILL_FAILED3});
    send_request('{hpc_pkg::CMD_GET, 32'd1, 64'h1001, 64'h123, hpc_pkg::FILL_OK});
    send_request('{hpc_pkg::CMD_GET, 32'd2, 64'h1001, 64'h456, hpc_pkg::FILL_OK});
    send_request('{hpc_pkg::CMD_FORGET, 32'd1, 64'd0, 64'd0, hpc_pkg::FILL_OK});
    send_request('{hpc_pkg::CMD_GET, 32'd1, 64'h1001, 64'h789, hpc_pkg::FILL_OK});
    send_request('{hpc_pkg::CMD_FORGET, 32'd7, 64'd0, 64'd0, hpc_pkg::FILL_OK});
    for (int i = 0; i < 40; i++) begin
      send_request('{hpc_pkg::CMD_GET, 32'd9, 64'(i) << 12, 64'(i + 100), hpc_pkg::FILL_OK});
    end
    send_request('{hpc_pkg::CMD_FORGET, 32'd9, 64'd0, 64'd0, hpc_pkg::FILL_OK});
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 61; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 61; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      for (int i = 0; i < 80; i++) begin
        if (i == 40 && phase == 1) drain();
        r = random_request();
        send_request(r);
      end
    end

    drain();
    repeat (200) @(negedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
